// ===== rtl/named_value_slot_table_macros.svh =====
// ----------------------------------------------------------------------------
// named value slot table assertion macros
// shared concurrent assertion forms, sampled on clock, off during reset
// ----------------------------------------------------------------------------
`ifndef NAMED_VALUE_SLOT_TABLE_MACROS_SVH
`define NAMED_VALUE_SLOT_TABLE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define NVST_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("nvst: implication check failed");

// condition holds at every edge
`define NVST_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("nvst: invariant check failed");

`endif

// ===== rtl/nvst_pkg.sv =====
// ----------------------------------------------------------------------------
// nvst_pkg
// types, codes and character helpers for the named value slot table
// ----------------------------------------------------------------------------
package nvst_pkg;

   localparam int SLOTS_DEFAULT       = 16;
   localparam int NAME_CHARS_DEFAULT  = 8;
   localparam int VALUE_CHARS_DEFAULT = 8;

   localparam int TEXT_W       = 64;
   localparam int TEXT_BYTES   = TEXT_W / 8;
   localparam int LEN_W        = 4;
   localparam int MODE_W       = 2;
   localparam int STATUS_W     = 3;
   localparam int USED_W       = 5;
   localparam int USED_MAX     = 31;
   localparam int MAX_RESULTS  = 16;
   localparam int RESULT_CNT_W = $clog2(MAX_RESULTS + 1);

   localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z   = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z   = 8'h7A;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_DIGIT_0   = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_9   = 8'h39;

   typedef enum logic [MODE_W-1:0] {
      MODE_SET   = 2'd0,
      MODE_UNSET = 2'd1,
      MODE_GET   = 2'd2,
      MODE_LIST  = 2'd3
   } mode_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK         = 3'd0,
      STATUS_BAD_NAME   = 3'd1,
      STATUS_VALUE_LONG = 3'd2,
      STATUS_NOT_FOUND  = 3'd3,
      STATUS_FULL       = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_LIST_SEEK,
      ST_LIST_DATA,
      ST_LIST_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      OUT_BLANK,
      OUT_GET,
      OUT_HOLD
   } out_sel_type;

   typedef struct packed {
      logic [TEXT_W-1:0] name_text;
      logic [LEN_W-1:0]  name_length;
      logic [TEXT_W-1:0] value_text;
      logic [LEN_W-1:0]  value_length;
   } entry_type;

   typedef struct packed {
      logic        req_ready;
      logic        idx_clr;
      logic        scan_issue;
      logic        list_read;
      logic        list_skip;
      logic        hold_load;
      logic        wr_entry;
      logic        clr_used;
      logic        out_load;
      status_type  out_status;
      out_sel_type out_sel;
      logic        out_last;
   } cmd_type;

   typedef struct packed {
      logic     req_valid;
      mode_type mode;
      logic     name_ok;
      logic     value_ok;
      logic     hit;
      logic     scan_end;
      logic     free_avail;
      logic     out_free;
      logic     list_used;
      logic     list_end;
      logic     hold_valid;
   } stat_type;

   function automatic logic [TEXT_W-1:0] text_mask(input logic [LEN_W-1:0] len);
      logic [TEXT_W-1:0] mask;
      int i;
      mask = '0;
      for (i = 0; i < TEXT_BYTES; i++) begin
         mask[i*8 +: 8] = (LEN_W'(i) < len) ? 8'hFF : 8'h00;
      end
      return mask;
   endfunction

   function automatic logic is_first_char(input logic [7:0] c);
      return ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_Z)) ||
             ((c >= CHAR_LOWER_A) && (c <= CHAR_LOWER_Z)) ||
             (c == CHAR_UNDERSCORE);
   endfunction

   function automatic logic is_rest_char(input logic [7:0] c);
      return is_first_char(c) || ((c >= CHAR_DIGIT_0) && (c <= CHAR_DIGIT_9));
   endfunction

   function automatic logic name_valid(input logic [TEXT_W-1:0] text,
                                       input logic [LEN_W-1:0]  len,
                                       input int                max_chars);
      logic ok;
      int i;
      ok = (len != '0) && (len <= LEN_W'(max_chars)) && is_first_char(text[7:0]);
      for (i = 1; i < TEXT_BYTES; i++) begin
         if ((LEN_W'(i) < len) && !is_rest_char(text[i*8 +: 8])) begin
            ok = 1'b0;
         end
      end
      return ok;
   endfunction

endpackage

// ===== rtl/nvst_req_if.sv =====
// ----------------------------------------------------------------------------
// nvst_req_if
// command channel: valid/ready with one command per beat
// ----------------------------------------------------------------------------
interface nvst_req_if
   import nvst_pkg::*;
;
   logic              valid;
   logic              ready;
   logic [MODE_W-1:0] mode;
   logic [TEXT_W-1:0] name_text;
   logic [LEN_W-1:0]  name_length;
   logic [TEXT_W-1:0] value_text;
   logic [LEN_W-1:0]  value_length;

   modport source (
      output valid, mode, name_text, name_length, value_text, value_length,
      input  ready
   );

   modport sink (
      input  valid, mode, name_text, name_length, value_text, value_length,
      output ready
   );
endinterface

// ===== rtl/nvst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nvst_rsp_if
// result channel: valid/ready with one result per beat
// ----------------------------------------------------------------------------
interface nvst_rsp_if
   import nvst_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [TEXT_W-1:0]   out_name_text;
   logic [LEN_W-1:0]    out_name_length;
   logic [TEXT_W-1:0]   out_value_text;
   logic [LEN_W-1:0]    out_value_length;
   logic [USED_W-1:0]   used_count;
   logic                last;

   modport source (
      output valid, status, out_name_text, out_name_length, out_value_text,
             out_value_length, used_count, last,
      input  ready
   );

   modport sink (
      input  valid, status, out_name_text, out_name_length, out_value_text,
             out_value_length, used_count, last,
      output ready
   );
endinterface

// ===== rtl/nvst_ram.sv =====
// ----------------------------------------------------------------------------
// nvst_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module nvst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                        wr_data,
   input  logic                                    rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/nvst_ctrl.sv =====
// ----------------------------------------------------------------------------
// nvst_ctrl
// command sequencer: check, slot scan, list walk and result hand-off
// ----------------------------------------------------------------------------
module nvst_ctrl
   import nvst_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  stat_type stat,
   output cmd_type  cmd
);
   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      cmd.out_status = STATUS_OK;
      cmd.out_sel    = OUT_BLANK;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.req_ready = !reset;
            if (stat.req_valid) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.mode == MODE_LIST) begin
               cmd.idx_clr = 1'b1;
               state_in    = ST_LIST_SEEK;
            end else if (stat.out_free) begin
               if ((stat.mode == MODE_SET) && !stat.name_ok) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = STATUS_BAD_NAME;
                  cmd.out_last   = 1'b1;
                  state_in       = ST_IDLE;
               end else if ((stat.mode == MODE_SET) && !stat.value_ok) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = STATUS_VALUE_LONG;
                  cmd.out_last   = 1'b1;
                  state_in       = ST_IDLE;
               end else begin
                  cmd.idx_clr = 1'b1;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            cmd.scan_issue = 1'b1;
            if (stat.hit) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
               unique case (stat.mode)
                  MODE_SET:   cmd.wr_entry = 1'b1;
                  MODE_UNSET: cmd.clr_used = 1'b1;
                  MODE_GET:   cmd.out_sel  = OUT_GET;
                  default:    cmd.out_sel  = OUT_BLANK;
               endcase
            end else if (stat.scan_end) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               state_in     = ST_IDLE;
               if (stat.mode == MODE_SET) begin
                  if (stat.free_avail) begin
                     cmd.wr_entry = 1'b1;
                  end else begin
                     cmd.out_status = STATUS_FULL;
                  end
               end else begin
                  cmd.out_status = STATUS_NOT_FOUND;
               end
            end
         end
         ST_LIST_SEEK: begin
            if (stat.list_end) begin
               state_in = ST_LIST_FLUSH;
            end else if (stat.list_used) begin
               cmd.list_read = 1'b1;
               state_in      = ST_LIST_DATA;
            end else begin
               cmd.list_skip = 1'b1;
            end
         end
         ST_LIST_DATA: begin
            if (!stat.hold_valid || stat.out_free) begin
               if (stat.hold_valid) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = OUT_HOLD;
               end
               cmd.hold_load = 1'b1;
               state_in      = ST_LIST_SEEK;
            end
         end
         ST_LIST_FLUSH: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = 1'b1;
               cmd.out_sel  = stat.hold_valid ? OUT_HOLD : OUT_BLANK;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end
endmodule

// ===== rtl/nvst_datapath.sv =====
// ----------------------------------------------------------------------------
// nvst_datapath
// request capture, slot store, match compare, list hold and result register
// ----------------------------------------------------------------------------
`include "named_value_slot_table_macros.svh"

module nvst_datapath
   import nvst_pkg::*;
#(
   parameter int SLOTS       = SLOTS_DEFAULT,
   parameter int NAME_CHARS  = NAME_CHARS_DEFAULT,
   parameter int VALUE_CHARS = VALUE_CHARS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   nvst_req_if.sink          req_if,
   nvst_rsp_if.source        rsp_if,
   input  cmd_type           cmd,
   output stat_type          stat
);
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int SAT_W = (CNT_W > USED_W) ? CNT_W : USED_W;

   // request capture
   logic              accept;
   mode_type          mode_ff;
   logic [TEXT_W-1:0] name_ff, name_in;
   logic [TEXT_W-1:0] value_ff, value_in;
   logic [LEN_W-1:0]  nlen_ff, vlen_ff;
   logic              name_ok_ff, name_ok_in;
   logic              value_ok_ff, value_ok_in;

   assign accept      = req_if.valid && cmd.req_ready;
   assign req_if.ready = cmd.req_ready;
   assign name_in     = req_if.name_text & text_mask(req_if.name_length);
   assign value_in    = req_if.value_text & text_mask(req_if.value_length);
   assign name_ok_in  = name_valid(req_if.name_text, req_if.name_length, NAME_CHARS);
   assign value_ok_in = req_if.value_length <= LEN_W'(VALUE_CHARS);

   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff     <= mode_type'(req_if.mode);
         name_ff     <= name_in;
         nlen_ff     <= req_if.name_length;
         value_ff    <= value_in;
         vlen_ff     <= req_if.value_length;
         name_ok_ff  <= name_ok_in;
         value_ok_ff <= value_ok_in;
      end
   end

   // slot store
   entry_type        rd_data;
   entry_type        wr_data;
   logic             rd_en;
   logic             wr_en;
   logic [IDX_W-1:0] rd_addr, wr_addr;

   nvst_ram #(
      .WIDTH ($bits(entry_type)),
      .DEPTH (SLOTS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // walk index and scan pipeline
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] idx_sel;
   logic             idx_end;
   logic             pend_ff, pend_in;
   logic [IDX_W-1:0] pend_idx_ff;
   logic             pend_used;
   logic             hit;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [IDX_W-1:0] free_sel;
   logic [SLOTS-1:0] used_ff, used_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign idx_end   = idx_ff == CNT_W'(SLOTS);
   assign idx_sel   = idx_ff[IDX_W-1:0];
   assign rd_en     = (cmd.scan_issue && !idx_end) || cmd.list_read;
   assign rd_addr   = idx_sel;
   assign pend_in   = cmd.scan_issue && !idx_end;
   assign pend_used = used_ff[pend_idx_ff];
   assign hit       = pend_ff && pend_used && (rd_data.name_length == nlen_ff) &&
                      (rd_data.name_text == name_ff);
   assign free_sel  = free_found_ff ? free_idx_ff : pend_idx_ff;

   always_comb begin
      idx_in = idx_ff;
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (rd_en || cmd.list_skip) begin
         idx_in = idx_ff + CNT_W'(1);
      end
   end

   always_comb begin
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (cmd.idx_clr) begin
         free_found_in = 1'b0;
      end else if (pend_ff && !pend_used && !free_found_ff) begin
         free_found_in = 1'b1;
         free_idx_in   = pend_idx_ff;
      end
   end

   assign wr_en   = cmd.wr_entry;
   assign wr_addr = hit ? pend_idx_ff : free_sel;
   assign wr_data = '{name_text: name_ff, name_length: nlen_ff,
                      value_text: value_ff, value_length: vlen_ff};

   always_comb begin
      used_in  = used_ff;
      count_in = count_ff;
      if (cmd.wr_entry) begin
         used_in[wr_addr] = 1'b1;
         if (!hit) begin
            count_in = count_ff + CNT_W'(1);
         end
      end
      if (cmd.clr_used) begin
         used_in[pend_idx_ff] = 1'b0;
         count_in             = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff        <= '0;
         pend_ff       <= 1'b0;
         free_found_ff <= 1'b0;
         used_ff       <= '0;
         count_ff      <= '0;
      end else begin
         idx_ff        <= idx_in;
         pend_ff       <= pend_in;
         free_found_ff <= free_found_in;
         used_ff       <= used_in;
         count_ff      <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= idx_sel;
      free_idx_ff <= free_idx_in;
   end

   // list hold stage, one entry behind so the final beat can carry last
   entry_type               hold_ff, hold_in;
   logic                    hold_valid_ff, hold_valid_in;
   logic [RESULT_CNT_W-1:0] k_ff, k_in;

   always_comb begin
      hold_in       = hold_ff;
      hold_valid_in = hold_valid_ff;
      k_in          = k_ff;
      if (cmd.idx_clr) begin
         hold_valid_in = 1'b0;
         k_in          = '0;
      end else if (cmd.hold_load) begin
         hold_in       = rd_data;
         hold_valid_in = 1'b1;
         k_in          = k_ff + RESULT_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         k_ff          <= '0;
      end else begin
         hold_valid_ff <= hold_valid_in;
         k_ff          <= k_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff <= hold_in;
   end

   // result register
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   status_type        status_ff;
   logic [TEXT_W-1:0] out_name_ff, out_name_in;
   logic [LEN_W-1:0]  out_nlen_ff, out_nlen_in;
   logic [TEXT_W-1:0] out_value_ff, out_value_in;
   logic [LEN_W-1:0]  out_vlen_ff, out_vlen_in;
   logic [USED_W-1:0] out_count_ff, out_count_in;
   logic              out_last_ff;
   logic [SAT_W-1:0]  count_wide;

   assign out_free     = !rsp_valid_ff || rsp_if.ready;
   assign rsp_valid_in = cmd.out_load || (rsp_valid_ff && !rsp_if.ready);
   assign count_wide   = SAT_W'(count_in);
   assign out_count_in = (count_wide > SAT_W'(USED_MAX)) ? USED_W'(USED_MAX)
                                                         : count_wide[USED_W-1:0];

   always_comb begin
      out_name_in  = '0;
      out_nlen_in  = '0;
      out_value_in = '0;
      out_vlen_in  = '0;
      case (cmd.out_sel)
         OUT_GET: begin
            out_value_in = rd_data.value_text;
            out_vlen_in  = rd_data.value_length;
         end
         OUT_HOLD: begin
            out_name_in  = hold_ff.name_text;
            out_nlen_in  = hold_ff.name_length;
            out_value_in = hold_ff.value_text;
            out_vlen_in  = hold_ff.value_length;
         end
         default: begin
            out_name_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         status_ff    <= cmd.out_status;
         out_name_ff  <= out_name_in;
         out_nlen_ff  <= out_nlen_in;
         out_value_ff <= out_value_in;
         out_vlen_ff  <= out_vlen_in;
         out_count_ff <= out_count_in;
         out_last_ff  <= cmd.out_last;
      end
   end

   assign rsp_if.valid            = rsp_valid_ff;
   assign rsp_if.status           = status_ff;
   assign rsp_if.out_name_text    = out_name_ff;
   assign rsp_if.out_name_length  = out_nlen_ff;
   assign rsp_if.out_value_text   = out_value_ff;
   assign rsp_if.out_value_length = out_vlen_ff;
   assign rsp_if.used_count       = out_count_ff;
   assign rsp_if.last             = out_last_ff;

   // status to the sequencer
   assign stat.req_valid  = req_if.valid;
   assign stat.mode       = mode_ff;
   assign stat.name_ok    = name_ok_ff;
   assign stat.value_ok   = value_ok_ff;
   assign stat.hit        = hit;
   assign stat.scan_end   = pend_ff && (pend_idx_ff == IDX_W'(SLOTS - 1));
   assign stat.free_avail = free_found_ff || (pend_ff && !pend_used);
   assign stat.out_free   = out_free;
   assign stat.list_used  = !idx_end && used_ff[idx_sel];
   assign stat.list_end   = idx_end || (k_ff == RESULT_CNT_W'(MAX_RESULTS));
   assign stat.hold_valid = hold_valid_ff;

   `NVST_ASSERT_IMPLY(a_new_slot_free, cmd.wr_entry && !hit, !used_ff[free_sel])
   `NVST_ASSERT_IMPLY(a_result_slot_free, cmd.out_load, out_free)
   `NVST_ASSERT_ALWAYS(a_count_tracks_used, $countones(used_ff) == count_ff)
endmodule

// ===== rtl/named_value_slot_table.sv =====
// ----------------------------------------------------------------------------
// named_value_slot_table
// fixed slot table of named values with set, unset, get and list commands
// ----------------------------------------------------------------------------
// channel  port    dir  beat
// command  req_if  in   mode, name and value text with lengths
// result   rsp_if  out  status, listed name/value, used count, last
//
// set, unset and get are captured, then checked, then scan the slots with
// one slot read per cycle and the compare in the cycle after its read.
// list walks the slots, reads each used one into the hold stage, up to 16 beats.
// reset clears the used marks and count; there is no clearing pass.
// a stalled result holds the next one back; a new command is still taken.
// ----------------------------------------------------------------------------
module named_value_slot_table
   import nvst_pkg::*;
#(
   parameter int SLOTS       = SLOTS_DEFAULT,
   parameter int NAME_CHARS  = NAME_CHARS_DEFAULT,
   parameter int VALUE_CHARS = VALUE_CHARS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   nvst_req_if.sink   req_if,
   nvst_rsp_if.source rsp_if
);
   cmd_type  cmd;
   stat_type stat;

   nvst_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .stat  (stat),
      .cmd   (cmd)
   );

   nvst_datapath #(
      .SLOTS       (SLOTS),
      .NAME_CHARS  (NAME_CHARS),
      .VALUE_CHARS (VALUE_CHARS)
   ) u_datapath (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .cmd    (cmd),
      .stat   (stat)
   );
endmodule
